>>> rtl/ska_pkg.sv
// Shared constants and types of the sorted key accumulation table.
`default_nettype none
package ska_pkg;

  localparam int CAPACITY      = 32;
  localparam int KEY_BITS      = 16;
  localparam int KEY_FIELD_W   = 16;
  localparam int SUM_W         = 32;
  localparam int COUNT_FIELD_W = 6;
  localparam int STATUS_W      = 3;
  // Stored key width: the key field caps the significant bits.
  localparam int KW            = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DUMP     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              insert_en;
    logic              update_en;
    logic              rotate;
    logic [KW-1:0]     key;
    logic [SUM_W-1:0]  amount;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/ska_cell.sv
// One entry of the sorted chain: key, running sum, compare and saturating add.
`default_nettype none
module ska_cell import ska_pkg::*; (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             valid_i,
  input  wire logic             left_lt_i,
  input  wire logic [KW-1:0]    left_key_i,
  input  wire logic [SUM_W-1:0] left_sum_i,
  input  wire logic [KW-1:0]    right_key_i,
  input  wire logic [SUM_W-1:0] right_sum_i,
  output logic [KW-1:0]         key_o,
  output logic [SUM_W-1:0]      sum_o,
  output logic                  lt_o,
  output logic                  eq_o,
  output logic [SUM_W-1:0]      new_sum_o
);

  logic [KW-1:0]    key_q, key_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W:0]   wide_sum;

  assign lt_o = valid_i && (key_q < ctrl_i.key);
  assign eq_o = valid_i && (key_q == ctrl_i.key);

  assign wide_sum = {sum_q[SUM_W-1], sum_q} + {ctrl_i.amount[SUM_W-1], ctrl_i.amount};

  always_comb begin
    if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
      new_sum_o = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      new_sum_o = wide_sum[SUM_W-1:0];
    end
  end

  // A cell whose left neighbor is not below the new key moves one place right;
  // the first cell not below the key takes the new entry.
  always_comb begin
    key_d = key_q;
    sum_d = sum_q;
    priority if (ctrl_i.rotate) begin
      key_d = right_key_i;
      sum_d = right_sum_i;
    end else if (ctrl_i.insert_en) begin
      priority if (!left_lt_i) begin
        key_d = left_key_i;
        sum_d = left_sum_i;
      end else if (!lt_o) begin
        key_d = ctrl_i.key;
        sum_d = ctrl_i.amount;
      end else begin
        key_d = key_q;
      end
    end else if (ctrl_i.update_en && eq_o) begin
      sum_d = new_sum_o;
    end else begin
      sum_d = sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sum_q <= sum_d;
  end

  assign key_o = key_q;
  assign sum_o = sum_q;

endmodule
`default_nettype wire

>>> rtl/sorted_key_accumulate_table.sv
// Top level of the sorted key accumulation table: cell chain and stream control.
//
// The slave stream carries one command word per transfer: tuser is the action
// (0 add, 1 dump), tdata holds the key and the signed amount. The master stream
// returns result words: tuser is the status, tdata holds key, sum and count,
// tlast marks the final word of a command.
// An add is compared against all entries at once and either updates the
// matching sum (saturating), inserts the key in order by shifting the cells
// above it, or is dropped when the table is full. Its word appears on the
// master side in the cycle after acceptance; adds are accepted back to back
// while the output register drains.
// A dump rotates the chain toward the first cell, sending one entry per cycle
// while the receiver takes them; no command is taken until the last entry is
// sent, after which the chain is back in order.
// An empty table gives one word with status dump empty.
// When the receiver stalls, the pending word holds and no new command is taken.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none
module sorted_key_accumulate_table import ska_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[15:0], amount[47:16]
  input  wire logic                  s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // entry_key, entry_sum, entry_count, 0
  output logic [STATUS_W-1:0]        m_axis_tuser,  // status
  output logic                       m_axis_tlast   // last
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic                     m_valid_q, m_valid_d;
  status_e                  status_q, status_d;
  logic [KEY_FIELD_W-1:0]   okey_q, okey_d;
  logic [SUM_W-1:0]         osum_q, osum_d;
  logic [COUNT_FIELD_W-1:0] ocnt_q, ocnt_d;
  logic                     olast_q, olast_d;

  logic [KW-1:0]       in_key;
  logic [SUM_W-1:0]    in_amount;
  logic                s_fire, out_free, load, found, full, do_insert, dump_emit;
  logic [SUM_W-1:0]    found_sum;
  cell_ctrl_t          ctrl;

  logic [KW-1:0]       key_w     [CAPACITY];
  logic [SUM_W-1:0]    sum_w     [CAPACITY];
  logic [SUM_W-1:0]    new_sum_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w, eq_w;

  assign in_key    = s_axis_tdata[KW-1:0];
  assign in_amount = s_axis_tdata[KEY_FIELD_W +: SUM_W];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign dump_emit     = (state_q == S_DUMP) && out_free;

  assign found     = |eq_w;
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign do_insert = s_fire && !s_axis_tuser && !found && !full;

  always_comb begin
    found_sum = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_sum = found_sum | (eq_w[i] ? new_sum_w[i] : '0);
    end
  end

  always_comb begin
    ctrl.insert_en = do_insert;
    ctrl.update_en = s_fire && !s_axis_tuser;
    ctrl.rotate    = dump_emit;
    ctrl.key       = in_key;
    ctrl.amount    = in_amount;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int Nxt = (g + 1) % CAPACITY;
    localparam int Prv = (g == 0) ? 0 : g - 1;
    logic is_last;
    logic [KW-1:0]    rkey;
    logic [SUM_W-1:0] rsum;

    // The last occupied cell wraps around to the head during a dump.
    assign is_last = (CNT_W'(g + 1) == count_q);
    assign rkey    = is_last ? key_w[0] : key_w[Nxt];
    assign rsum    = is_last ? sum_w[0] : sum_w[Nxt];

    ska_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (CNT_W'(g) < count_q),
      .left_lt_i   ((g == 0) ? 1'b1 : lt_w[Prv]),
      .left_key_i  (key_w[Prv]),
      .left_sum_i  (sum_w[Prv]),
      .right_key_i (rkey),
      .right_sum_i (rsum),
      .key_o       (key_w[g]),
      .sum_o       (sum_w[g]),
      .lt_o        (lt_w[g]),
      .eq_o        (eq_w[g]),
      .new_sum_o   (new_sum_w[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    load     = 1'b0;
    status_d = status_q;
    okey_d   = okey_q;
    osum_d   = osum_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser) begin
            if (count_q == '0) begin
              load     = 1'b1;
              status_d = ST_EMPTY;
              okey_d   = '0;
              osum_d   = '0;
              ocnt_d   = '0;
              olast_d  = 1'b1;
            end else begin
              state_d = S_DUMP;
              idx_d   = '0;
            end
          end else begin
            load    = 1'b1;
            okey_d  = KEY_FIELD_W'(in_key);
            ocnt_d  = COUNT_FIELD_W'(count_q);
            olast_d = 1'b1;
            priority if (found) begin
              status_d = ST_UPDATED;
              osum_d   = found_sum;
            end else if (full) begin
              status_d = ST_DROPPED;
              osum_d   = '0;
            end else begin
              status_d = ST_INSERTED;
              osum_d   = in_amount;
              count_d  = CNT_W'(count_q + 1'b1);
              ocnt_d   = COUNT_FIELD_W'(CNT_W'(count_q + 1'b1));
            end
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          status_d = ST_DUMP;
          okey_d   = KEY_FIELD_W'(key_w[0]);
          osum_d   = sum_w[0];
          ocnt_d   = COUNT_FIELD_W'(count_q);
          olast_d  = (CNT_W'(idx_q + 1'b1) == count_q);
          idx_d    = CNT_W'(idx_q + 1'b1);
          if (CNT_W'(idx_q + 1'b1) == count_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    okey_q   <= okey_d;
    osum_q   <= osum_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - KEY_FIELD_W - SUM_W - COUNT_FIELD_W){1'b0}},
                          ocnt_q, osum_q, okey_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_accept_in_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !s_axis_tready)
    else $error("command accepted during dump");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("insert did not grow the table");

  a_dump_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_emit && olast_d) |=> (state_q == S_IDLE) && m_axis_tlast)
    else $error("dump did not finish on its last word");

  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(eq_w))
    else $error("key stored twice");

endmodule
`default_nettype wire

>>> tb/sorted_key_accumulate_table_tb.sv
// Self-checking testbench for the sorted key accumulation table: directed and random streams.
`default_nettype none
module sorted_key_accumulate_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ska_pkg::*;

  localparam int IDLE_PCT     = 36;
  localparam int RANDOM_ITEMS = 64;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_DUMP   = 1'b1;
  localparam logic [KEY_FIELD_W-1:0] KEY_MASK = KEY_FIELD_W'((64'd1 << KEY_BITS) - 1);

  typedef struct {
    status_e                  status;
    logic [KEY_FIELD_W-1:0]   key;
    logic [SUM_W-1:0]         sum;
    logic [COUNT_FIELD_W-1:0] count;
    logic                     last;
  } entry_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = ACT_ADD;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  // Shadow copy of the table, updated on every accepted command word.
  logic [KEY_FIELD_W-1:0] tbl_keys[CAPACITY];
  logic [SUM_W-1:0]       tbl_sums[CAPACITY];
  int                     tbl_count = 0;
  entry_word_t            expected_words[$];

  int  err_count = 0;
  int  commands_seen = 0;
  int  n_updated = 0, n_inserted = 0, n_dropped = 0, n_dump_words = 0, n_empty = 0;
  int  n_dumps = 0, peak_count = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  rx_hold_request = 0;
  int  rx_hold_left = 0;

  sorted_key_accumulate_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [SUM_W-1:0] saturating_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    longint r;
    r = longint'($signed(a)) + longint'($signed(b));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[SUM_W-1:0];
  endfunction

  function automatic void push_word(status_e st, logic [KEY_FIELD_W-1:0] k,
                                    logic [SUM_W-1:0] s, int n, logic lst);
    entry_word_t w;
    w.status = st;
    w.key    = k;
    w.sum    = s;
    w.count  = COUNT_FIELD_W'(n);
    w.last   = lst;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_command(logic act, logic [KEY_FIELD_W-1:0] key_in,
                                          logic [SUM_W-1:0] amount);
    logic [KEY_FIELD_W-1:0] k;
    int pos;
    k = key_in & KEY_MASK;
    if (act == ACT_DUMP) begin
      if (tbl_count == 0) begin
        push_word(ST_EMPTY, '0, '0, 0, 1'b1);
        return;
      end
      for (int i = 0; i < tbl_count; i++)
        push_word(ST_DUMP, tbl_keys[i], tbl_sums[i], tbl_count, i == tbl_count - 1);
      return;
    end
    pos = 0;
    while (pos < tbl_count && tbl_keys[pos] < k) pos++;
    if (pos < tbl_count && tbl_keys[pos] == k) begin
      tbl_sums[pos] = saturating_sum(tbl_sums[pos], amount);
      push_word(ST_UPDATED, k, tbl_sums[pos], tbl_count, 1'b1);
    end else if (tbl_count >= CAPACITY) begin
      push_word(ST_DROPPED, k, '0, tbl_count, 1'b1);
    end else begin
      for (int i = tbl_count; i > pos; i--) begin
        tbl_keys[i] = tbl_keys[i-1];
        tbl_sums[i] = tbl_sums[i-1];
      end
      tbl_keys[pos] = k;
      tbl_sums[pos] = amount;
      tbl_count++;
      if (tbl_count > peak_count) peak_count = tbl_count;
      push_word(ST_INSERTED, k, amount, tbl_count, 1'b1);
    end
  endfunction

  function automatic bit key_stored(logic [KEY_FIELD_W-1:0] k);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [SUM_W-1:0] rand_amount();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // Command side: every word seen accepted goes through the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);
      commands_seen++;
    end
  end

  // Result side: each accepted word is matched against the oldest expectation.
  always @(posedge clk_i) begin
    entry_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d key %h", m_axis_tuser, m_axis_tdata[15:0]);
        err_count++;
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tuser !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[15:0] !== w.key) begin
          $error("entry_key: expected %h, got %h", w.key, m_axis_tdata[15:0]);
          err_count++;
        end
        if (m_axis_tdata[47:16] !== w.sum) begin
          $error("entry_sum: expected %0d, got %0d", $signed(w.sum),
                 $signed(m_axis_tdata[47:16]));
          err_count++;
        end
        if (m_axis_tdata[53:48] !== w.count) begin
          $error("entry_count: expected %0d, got %0d", w.count, m_axis_tdata[53:48]);
          err_count++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, m_axis_tlast);
          err_count++;
        end
        case (w.status)
          ST_UPDATED:  n_updated++;
          ST_INSERTED: n_inserted++;
          ST_DROPPED:  n_dropped++;
          ST_DUMP: begin
            n_dump_words++;
            if (w.last) n_dumps++;
          end
          default:     n_empty++;
        endcase
      end
    end
  end

  // Receiver: random stalls, steady stretches, and long hold-offs on request.
  always @(posedge clk_i) begin
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic act, input logic [KEY_FIELD_W-1:0] k,
                           input logic [SUM_W-1:0] amount);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {amount, k};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Always moves past the accepting edge, so the predictor has seen the last word.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_dump();
    // Key and amount must be ignored on a dump.
    send_word(ACT_DUMP, 16'hFFFF, 32'h8000_0000);
    wait_drained();
  endtask

  task automatic test_saturation();
    send_word(ACT_ADD, 16'h0000, 32'h7FFF_FFFF);
    send_word(ACT_ADD, 16'h0000, 32'd1);
    send_word(ACT_ADD, 16'h0000, 32'h8000_0000);
    send_word(ACT_ADD, 16'hFFFF, 32'h8000_0000);
    send_word(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(ACT_ADD, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(ACT_DUMP, 16'h0000, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_sorted_insert();
    send_word(ACT_ADD, 16'h8000, 32'd0);
    send_word(ACT_ADD, 16'h0001, 32'd7);
    send_word(ACT_ADD, 16'hFFFE, 32'hFFFF_FFF0);
    send_word(ACT_ADD, 16'h4000, 32'd3);
    send_word(ACT_ADD, 16'h8000, 32'd5);
    send_word(ACT_DUMP, 16'h1234, 32'h5555_AAAA);
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_hold_request = HOLD_CYCLES;
    tx_steady = 1'b1;
    for (int i = 0; i < 14; i++) begin
      if (i == 7) send_word(ACT_DUMP, '0, '0);
      else send_word(ACT_ADD, 16'($urandom_range(16'h00FF)), rand_amount());
    end
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [KEY_FIELD_W-1:0] k;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_steady = (i >= 24 && i < 50);
      rx_steady = (i >= 24 && i < 50);
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_word(ACT_DUMP, 16'($urandom), $urandom);
      end else begin
        if (pick < 55 && tbl_count > 0) k = tbl_keys[$urandom_range(tbl_count - 1)];
        else k = 16'($urandom);
        send_word(ACT_ADD, k, rand_amount());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [KEY_FIELD_W-1:0] k;
    while (tbl_count < CAPACITY) send_word(ACT_ADD, 16'($urandom), rand_amount());
    wait_drained();
    do k = 16'($urandom); while (key_stored(k));
    send_word(ACT_ADD, k, rand_amount());
    send_word(ACT_ADD, tbl_keys[0], rand_amount());
    send_word(ACT_ADD, tbl_keys[CAPACITY-1], rand_amount());
    send_word(ACT_DUMP, '0, '0);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_dump();
    test_saturation();
    test_sorted_insert();
    test_backpressure();
    test_random_traffic();
    test_full_table();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d commands: %0d inserted, %0d updated, %0d dropped on a full table",
             commands_seen, n_inserted, n_updated, n_dropped);
    $display("%0d dumps gave %0d entry words, %0d empty dumps, peak of %0d entries",
             n_dumps, n_dump_words, n_empty, peak_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
